// ===== rtl/core/trb_pkg.sv =====
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types and constants for the timestamp reorder buffer.
// ----------------------------------------------------------------------------
package trb_pkg;

  localparam int SEC_W = 32;
  localparam int MS_W  = 10;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SEND,
    S_PACK
  } state_t;

endpackage

// ===== rtl/core/trb_if.sv =====
// ----------------------------------------------------------------------------
// trb_in_if / trb_out_if
// Valid/ready channels for push/flush beats and ordered result beats.
// ----------------------------------------------------------------------------
interface trb_in_if import trb_pkg::*; #(parameter int TAG_BITS = 16) ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SEC_W-1:0]    time_seconds;
  logic [MS_W-1:0]     time_millis;
  logic [TAG_BITS-1:0] message_tag;

  modport source (output valid, opcode, time_seconds, time_millis, message_tag,
                  input ready);
  modport sink (input valid, opcode, time_seconds, time_millis, message_tag,
                output ready);
endinterface

interface trb_out_if import trb_pkg::*; #(parameter int TAG_BITS = 16) ();
  logic                valid;
  logic                ready;
  logic [TAG_BITS-1:0] out_tag;
  logic [SEC_W-1:0]    out_seconds;
  logic [MS_W-1:0]     out_millis;
  logic                last;

  modport source (output valid, out_tag, out_seconds, out_millis, last,
                  input ready);
  modport sink (input valid, out_tag, out_seconds, out_millis, last,
                output ready);
endinterface

// ===== rtl/core/timestamp_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// timestamp_reorder_buffer
// Collects timestamped tags and emits them oldest first.
// ----------------------------------------------------------------------------
// req carries push and flush beats; rsp carries result beats, oldest first,
// with last on the final beat of a run. A push below capacity is taken
// without starting a run. The push that fills the store starts a run that
// emits the oldest CAPACITY/2 entries; a flush emits all stored entries and
// empties the store. Each result beat needs a full read sweep of the entry
// memory to select the oldest entry not yet sent. A push run ends with a
// compaction sweep that packs the kept entries to the front in arrival
// order. Equal timestamps leave in arrival order. req is not ready while a
// run is active. A stalled rsp holds its beat and the run waits. Reset
// empties the store at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module timestamp_reorder_buffer import trb_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  trb_in_if.sink    req,
  trb_out_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KEY_W = SEC_W + MS_W;
  localparam int ENT_W = KEY_W + TAG_BITS;
  localparam logic [CNT_W-1:0] CAP  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] HALF = CNT_W'(CAPACITY / 2);

  logic [ENT_W-1:0] mem [CAPACITY];
  logic [ENT_W-1:0] rdata;

  state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] target;
  logic [CNT_W-1:0] sent;
  logic [CNT_W-1:0] wptr;
  logic             flush_run;
  logic [IDX_W-1:0] scan_idx;
  logic             issuing;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic [CAPACITY-1:0] done;
  logic             have;
  logic [IDX_W-1:0] best_idx;
  logic [ENT_W-1:0] best;

  logic             push_acc, flush_acc, scan_end, pack_end, send_acc, run_end;
  logic             take;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [ENT_W-1:0] wdata;

  assign push_acc  = req.valid && req.ready && (req.opcode == OP_PUSH);
  assign flush_acc = req.valid && req.ready && (req.opcode == OP_FLUSH)
                     && (count != '0);
  assign scan_end  = (state == S_SCAN) && rd_vld && (CNT_W'(rd_idx) + 1'b1 == count);
  assign pack_end  = (state == S_PACK) && rd_vld && (CNT_W'(rd_idx) + 1'b1 == count);
  assign send_acc  = (state == S_SEND) && rsp.ready;
  assign run_end   = send_acc && (sent + 1'b1 == target);
  assign take      = rd_vld && !done[rd_idx]
                     && (!have || rdata[ENT_W-1 -: KEY_W] < best[ENT_W-1 -: KEY_W]);

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (flush_acc || (push_acc && count + 1'b1 == CAP)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_SEND;
        end
      end
      S_SEND: begin
        rsp.valid = 1'b1;
        if (run_end) begin
          state_next = flush_run ? S_IDLE : S_PACK;
        end else if (send_acc) begin
          state_next = S_SCAN;
        end
      end
      S_PACK: begin
        if (pack_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp.out_tag     = best[TAG_BITS-1:0];
  assign rsp.out_millis  = best[TAG_BITS +: MS_W];
  assign rsp.out_seconds = best[ENT_W-1 -: SEC_W];
  assign rsp.last        = (sent + 1'b1 == target);

  always_comb begin
    we    = 1'b0;
    waddr = count[IDX_W-1:0];
    wdata = {req.time_seconds, req.time_millis, req.message_tag};
    if (push_acc) begin
      we = 1'b1;
    end else if ((state == S_PACK) && rd_vld && !done[rd_idx]) begin
      we    = 1'b1;
      waddr = wptr[IDX_W-1:0];
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sent      <= '0;
      target    <= '0;
      wptr      <= '0;
      flush_run <= 1'b0;
      scan_idx  <= '0;
      issuing   <= 1'b0;
      rd_vld    <= 1'b0;
      rd_idx    <= '0;
      done      <= '0;
      have      <= 1'b0;
    end else begin
      rd_vld <= issuing;
      rd_idx <= scan_idx;
      if (issuing) begin
        if (CNT_W'(scan_idx) + 1'b1 == count) begin
          issuing <= 1'b0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (push_acc) begin
        count <= count + 1'b1;
      end
      if (state == S_IDLE && state_next == S_SCAN) begin
        flush_run <= flush_acc;
        target    <= flush_acc ? count : HALF;
        sent      <= '0;
        scan_idx  <= '0;
        issuing   <= 1'b1;
        have      <= 1'b0;
      end
      if (state == S_SCAN && take) begin
        have     <= 1'b1;
        best     <= rdata;
        best_idx <= rd_idx;
      end
      if (send_acc) begin
        done[best_idx] <= 1'b1;
        sent           <= sent + 1'b1;
        scan_idx       <= '0;
        issuing        <= 1'b1;
        have           <= 1'b0;
        wptr           <= '0;
        if (run_end && flush_run) begin
          count   <= '0;
          done    <= '0;
          issuing <= 1'b0;
        end
      end
      if (state == S_PACK && rd_vld && !done[rd_idx]) begin
        wptr <= wptr + 1'b1;
      end
      if (pack_end) begin
        count <= count - HALF;
        done  <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP) else $error("entry count above capacity");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (send_acc && run_end && flush_run) |=> (count == '0))
    else $error("store not empty after flush run");

  a_pack_count: assert property (@(posedge clk) disable iff (rst)
    pack_end |=> (count == CAP - HALF))
    else $error("wrong count after compaction");

endmodule
